/* rtl/core/accented_metronome_scheduler_top_assert.svh */
// ----------------------------------------------------------------------------
// Accented metronome scheduler: assertion macros
// Shared concurrent assertion forms, clocked on aclk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef ACCENTED_METRONOME_SCHEDULER_TOP_ASSERT_SVH
`define ACCENTED_METRONOME_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication
`define AMS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ams assertion failed");

// Next-cycle implication
`define AMS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ams assertion failed");

`endif

/* rtl/core/amsch_pkg.sv */
// ----------------------------------------------------------------------------
// amsch_pkg
// Types, constants and small table functions for the metronome scheduler.
// ----------------------------------------------------------------------------
package amsch_pkg;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = TIME_W / DIGIT_W;
    localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);
    localparam int BPM_W      = 9;
    localparam int SIG_W      = 3;
    localparam int VOL_W      = 7;
    localparam int SIL_W      = 3;
    localparam int ACC_BARS_W = 4;
    localparam int TPS_W      = 10;
    localparam int INT_W      = 16;
    localparam int BAR_W      = 16;
    localparam int MAX_BEATS  = 8;
    localparam int POS_W      = $clog2(MAX_BEATS);
    localparam int HZ_W       = 11;
    localparam int MS_W       = 6;

    // Divider sizes
    localparam int DIVD_W     = 16;
    localparam int DIVS_W     = 9;
    localparam int DIV_CNT_W  = $clog2(DIVD_W);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Result item packing
    localparam int M_TDATA_W  = 56;

    localparam logic [BPM_W-1:0] TEMPO_STEP = BPM_W'(5);
    localparam int NUM_SIGS = 6;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BPM    = 3'd0,
        CFG_TIME_SIG     = 3'd1,
        CFG_VOLUME       = 3'd2,
        CFG_SILENT_BARS  = 3'd3,
        CFG_ACCEL_BARS   = 3'd4,
        CFG_ACCEL_TARGET = 3'd5,
        CFG_TICKS_PER_S  = 3'd6
    } cfg_reg_t;

    // Accent codes
    typedef enum logic [1:0] {
        ACC_NONE   = 2'd0,
        ACC_WEAK   = 2'd1,
        ACC_MEDIUM = 2'd2,
        ACC_STRONG = 2'd3
    } accent_t;

    // Click tones
    localparam logic [HZ_W-1:0] HZ_STRONG = HZ_W'(1200);
    localparam logic [HZ_W-1:0] HZ_MEDIUM = HZ_W'(1000);
    localparam logic [HZ_W-1:0] HZ_WEAK   = HZ_W'(800);
    localparam logic [MS_W-1:0] MS_STRONG = MS_W'(60);
    localparam logic [MS_W-1:0] MS_MEDIUM = MS_W'(50);
    localparam logic [MS_W-1:0] MS_WEAK   = MS_W'(40);

    // Beats per bar for 2/4 3/4 4/4 6/8 5/4 7/8
    localparam logic [POS_W-1:0] SIG_BEATS [NUM_SIGS] = '{
        3'd2, 3'd3, 3'd4, 3'd6, 3'd5, 3'd7
    };

    localparam logic [1:0] SIG_ACCENT [NUM_SIGS][MAX_BEATS] = '{
        '{2'd3, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd3, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd3, 2'd1, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd3, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0},
        '{2'd3, 2'd1, 2'd2, 2'd1, 2'd3, 2'd0, 2'd0, 2'd0},
        '{2'd3, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd3, 2'd0}
    };

    // Divider handshake
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [DIVS_W-1:0] remainder;
    } div_rsp_t;

    // Time adder handshake
    typedef struct packed {
        logic              start;
        logic              sub;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [TIME_W-1:0] sum;
    } alu_rsp_t;

    // Unknown signature codes act as 7/8
    function automatic logic [SIG_W-1:0] sig_clamp(input logic [SIG_W-1:0] sig);
        return (sig >= SIG_W'(NUM_SIGS)) ? SIG_W'(NUM_SIGS - 1) : sig;
    endfunction

    function automatic logic [POS_W-1:0] beats_of(input logic [SIG_W-1:0] sig);
        return SIG_BEATS[sig_clamp(sig)];
    endfunction

    // Accent of a position, position taken modulo the beat count
    function automatic logic [1:0] accent_of(input logic [SIG_W-1:0] sig,
                                             input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] nb;
        logic [POS_W-1:0] r;
        nb = beats_of(sig);
        r  = pos;
        for (int k = 0; k < 3; k++) begin
            if (r >= nb) begin
                r = r - nb;
            end
        end
        return SIG_ACCENT[sig_clamp(sig)][r];
    endfunction

    // x / 5 for x below 512, by reciprocal 205/1024
    function automatic logic [VOL_W-1:0] div5(input logic [8:0] x);
        logic [16:0] p;
        p = 17'(x) * 17'(205);
        return p[16:10];
    endfunction

endpackage

/* rtl/core/amsch_div.sv */
// ----------------------------------------------------------------------------
// amsch_div
// Restoring divider, one quotient bit per cycle, quotient shifted into the
// dividend register.
// ----------------------------------------------------------------------------
module amsch_div
    import amsch_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIVD_W-1:0]    dvd_reg;
    logic [DIVS_W-1:0]    dvs_reg;
    logic [DIVS_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIVS_W:0]      rem_sh;
    logic                 ge;
    logic [DIVS_W:0]      rem_sub;

    // One restoring step
    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[DIVD_W-1]};
        ge      = (rem_sh >= {1'b0, dvs_reg});
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                dvd_reg <= {dvd_reg[DIVD_W-2:0], ge};
                rem_reg <= ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else if (req.start) begin
                dvd_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* rtl/core/amsch_tadd.sv */
// ----------------------------------------------------------------------------
// amsch_tadd
// Digit-serial 32-bit time adder/subtractor, one 4-bit digit per cycle,
// low digit first, carry kept in a flop between digits.
// ----------------------------------------------------------------------------
module amsch_tadd
    import amsch_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [TIME_W-1:0]      a_reg;
    logic [TIME_W-1:0]      b_reg;
    logic [TIME_W-1:0]      sum_reg;
    logic                   carry_reg;
    logic [DIGIT_CNT_W-1:0] cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [DIGIT_W:0]       dsum;

    // Digit adder
    assign dsum = {1'b0, a_reg[DIGIT_W-1:0]} + {1'b0, b_reg[DIGIT_W-1:0]}
                + {{DIGIT_W{1'b0}}, carry_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                a_reg     <= a_reg >> DIGIT_W;
                b_reg     <= b_reg >> DIGIT_W;
                sum_reg   <= {dsum[DIGIT_W-1:0], sum_reg[TIME_W-1:DIGIT_W]};
                carry_reg <= dsum[DIGIT_W];
                cnt_reg   <= cnt_reg + 1'b1;
                if (cnt_reg == DIGIT_CNT_W'(NUM_DIGITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else if (req.start) begin
                // subtract as a + ~b + 1
                a_reg     <= req.a;
                b_reg     <= req.sub ? ~req.b : req.b;
                carry_reg <= req.sub;
                cnt_reg   <= '0;
                busy_reg  <= 1'b1;
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.sum  = sum_reg;

endmodule

/* rtl/core/accented_metronome_scheduler_top.sv */
// ----------------------------------------------------------------------------
// accented_metronome_scheduler_top
// Metronome beat scheduler with accents, silent bars and gradual tempo rise.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per time event; s_tuser is the command (0 = time
//   check, 1 = play/pause toggle), s_tdata the current 32-bit tick time.
//   m_ channel: exactly one result item per input item, in order.
//   cfg channel: register writes (index, data), always ready; write only
//   while no item is in flight.
// Throughput: one item at a time; a new item is taken only in idle. The
// time per item is set by the 4-bit digit-serial time adder (32-bit adds
// and compares) and the bit-serial divider (remainders and beat
// intervals), both used in turn by the sequencer.
// Reset (aresetn low, synchronous): stopped, counters and schedule cleared,
// tempo 120 BPM, registers at their defaults.
// Stall: the result sits in an output register; a new item is taken while
// it waits, but the next result holds until m_tready takes the old one.
// ----------------------------------------------------------------------------
module accented_metronome_scheduler_top
    import amsch_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TIME_W-1:0]     s_tdata,   // [31:0] now
    input  logic                  s_tuser,   // [0] command
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] accent, [2] silent, [13:3] tone_hz, [19:14] tone_ms,
    // [26:20] tone_level, [29:27] beat_index, [45:30] bar_number,
    // [54:46] tempo_bpm, [55] running
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser,   // [0] beat
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "accented_metronome_scheduler_top_assert.svh"

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMP,
        ST_CMP_W,
        ST_SIL_W,
        ST_ADV,
        ST_ACC_W,
        ST_INT,
        ST_INT_W,
        ST_RST,
        ST_RST_W,
        ST_STEP,
        ST_STEP_W,
        ST_LATE_W,
        ST_FIX_W,
        ST_EMIT
    } state_t;

    // Configuration registers
    logic [SIG_W-1:0]      tsig_reg;
    logic [VOL_W-1:0]      volume_reg;
    logic [SIL_W-1:0]      silent_bars_reg;
    logic [ACC_BARS_W-1:0] accel_bars_reg;
    logic [BPM_W-1:0]      target_reg;
    logic [TPS_W-1:0]      tps_reg;

    // Schedule state
    state_t                state_reg;
    logic                  playing_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [BAR_W-1:0]      bar_reg;
    logic [BPM_W-1:0]      tempo_reg;
    logic [INT_W-1:0]      interval_reg;
    logic [TIME_W-1:0]     next_reg;

    // Current item and its result fields
    logic                  cmd_reg;
    logic [TIME_W-1:0]     now_reg;
    logic                  fired_reg;
    logic [1:0]            acc_reg;
    logic                  sil_reg;
    logic [HZ_W-1:0]       hz_reg;
    logic [MS_W-1:0]       ms_reg;
    logic [VOL_W-1:0]      lvl_reg;
    logic [POS_W-1:0]      idx_reg;

    // Output register
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic                  m_tuser_reg;

    // Unit requests
    alu_req_t              alu_req_reg;
    alu_rsp_t              alu_rsp;
    div_req_t              div_req_reg;
    div_rsp_t              div_rsp;

    // Helpers
    logic                  s_accept;
    logic                  cfg_write;
    logic [POS_W-1:0]      pos_next;
    logic [BAR_W-1:0]      bar_next;
    logic [BPM_W:0]        tempo_inc;
    logic [BPM_W-1:0]      tempo_next;
    logic [DIVD_W-1:0]     tps60;
    logic [VOL_W-1:0]      lvl8;
    logic [VOL_W-1:0]      lvl6;

    assign s_accept  = s_tvalid && s_tready;
    assign cfg_write = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        pos_next   = pos_reg + 1'b1;
        bar_next   = bar_reg + 1'b1;
        tempo_inc  = {1'b0, tempo_reg} + {1'b0, TEMPO_STEP};
        tempo_next = (tempo_inc > {1'b0, target_reg}) ? target_reg : tempo_inc[BPM_W-1:0];
        // 60 * tps as 64*tps - 4*tps
        tps60      = {tps_reg, 6'b0} - {4'b0, tps_reg, 2'b0};
        lvl8       = div5({volume_reg, 2'b0});
        lvl6       = div5(9'({volume_reg, 1'b0}) + 9'(volume_reg));
    end

    // Configuration registers (start tempo lives with the sequencer)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tsig_reg        <= SIG_W'(2);
            volume_reg      <= VOL_W'(80);
            silent_bars_reg <= '0;
            accel_bars_reg  <= '0;
            target_reg      <= BPM_W'(120);
            tps_reg         <= TPS_W'(100);
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_TIME_SIG:     tsig_reg        <= cfg_data[SIG_W-1:0];
                CFG_VOLUME:       volume_reg      <= cfg_data[VOL_W-1:0];
                CFG_SILENT_BARS:  silent_bars_reg <= cfg_data[SIL_W-1:0];
                CFG_ACCEL_BARS:   accel_bars_reg  <= cfg_data[ACC_BARS_W-1:0];
                CFG_ACCEL_TARGET: target_reg      <= cfg_data[BPM_W-1:0];
                CFG_TICKS_PER_S:  tps_reg         <= cfg_data[TPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Serial units
    amsch_tadd u_tadd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req_reg),
        .rsp     (alu_rsp)
    );

    amsch_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req_reg),
        .rsp     (div_rsp)
    );

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            playing_reg       <= 1'b0;
            pos_reg           <= '0;
            bar_reg           <= '0;
            tempo_reg         <= BPM_W'(120);
            interval_reg      <= '0;
            next_reg          <= '0;
            m_tvalid_reg      <= 1'b0;
            alu_req_reg.start <= 1'b0;
            div_req_reg.start <= 1'b0;
        end else begin
            alu_req_reg.start <= 1'b0;
            div_req_reg.start <= 1'b0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_write && cfg_index == CFG_START_BPM) begin
                tempo_reg <= cfg_data[BPM_W-1:0];
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        cmd_reg   <= s_tuser;
                        now_reg   <= s_tdata;
                        fired_reg <= 1'b0;
                        acc_reg   <= ACC_NONE;
                        sil_reg   <= 1'b0;
                        hz_reg    <= '0;
                        ms_reg    <= '0;
                        lvl_reg   <= '0;
                        idx_reg   <= '0;
                        if (s_tuser) begin
                            state_reg <= ST_INT;
                        end else if (playing_reg) begin
                            state_reg <= ST_CMP;
                        end else begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end

                // now - next, sign says whether the beat is due
                ST_CMP: begin
                    alu_req_reg <= '{start: 1'b1, sub: 1'b1, a: now_reg, b: next_reg};
                    state_reg   <= ST_CMP_W;
                end

                ST_CMP_W: begin
                    if (alu_rsp.done) begin
                        if (alu_rsp.sum[TIME_W-1]) begin
                            state_reg <= ST_EMIT;
                        end else begin
                            fired_reg <= 1'b1;
                            idx_reg   <= pos_reg;
                            acc_reg   <= accent_of(tsig_reg, pos_reg);
                            if (silent_bars_reg != '0) begin
                                div_req_reg <= '{start: 1'b1, dividend: bar_reg,
                                    divisor: DIVS_W'(silent_bars_reg) + 1'b1};
                                state_reg   <= ST_SIL_W;
                            end else begin
                                state_reg <= ST_ADV;
                            end
                        end
                    end
                end

                ST_SIL_W: begin
                    if (div_rsp.done) begin
                        sil_reg   <= (div_rsp.remainder == '0);
                        state_reg <= ST_ADV;
                    end
                end

                // Tone, position and bar advance
                ST_ADV: begin
                    if (!sil_reg) begin
                        unique case (acc_reg)
                            ACC_STRONG: begin
                                hz_reg  <= HZ_STRONG;
                                ms_reg  <= MS_STRONG;
                                lvl_reg <= volume_reg;
                            end
                            ACC_MEDIUM: begin
                                hz_reg  <= HZ_MEDIUM;
                                ms_reg  <= MS_MEDIUM;
                                lvl_reg <= lvl8;
                            end
                            ACC_WEAK: begin
                                hz_reg  <= HZ_WEAK;
                                ms_reg  <= MS_WEAK;
                                lvl_reg <= lvl6;
                            end
                            default: ;
                        endcase
                    end
                    if (pos_next >= beats_of(tsig_reg)) begin
                        pos_reg <= '0;
                        bar_reg <= bar_next;
                        if (accel_bars_reg != '0) begin
                            div_req_reg <= '{start: 1'b1, dividend: bar_next,
                                divisor: DIVS_W'(accel_bars_reg)};
                            state_reg   <= ST_ACC_W;
                        end else begin
                            state_reg <= ST_STEP;
                        end
                    end else begin
                        pos_reg   <= pos_next;
                        state_reg <= ST_STEP;
                    end
                end

                ST_ACC_W: begin
                    if (div_rsp.done) begin
                        if (div_rsp.remainder == '0 && tempo_reg < target_reg) begin
                            tempo_reg <= tempo_next;
                            state_reg <= ST_INT;
                        end else begin
                            state_reg <= ST_STEP;
                        end
                    end
                end

                // Interval = 60 * tps / tempo, zero tempo saturates
                ST_INT: begin
                    if (tempo_reg == '0) begin
                        interval_reg <= '1;
                        state_reg    <= cmd_reg ? ST_RST : ST_STEP;
                    end else begin
                        div_req_reg <= '{start: 1'b1, dividend: tps60,
                            divisor: tempo_reg};
                        state_reg   <= ST_INT_W;
                    end
                end

                ST_INT_W: begin
                    if (div_rsp.done) begin
                        interval_reg <= div_rsp.quotient;
                        state_reg    <= cmd_reg ? ST_RST : ST_STEP;
                    end
                end

                // Restart: next = now + interval
                ST_RST: begin
                    alu_req_reg <= '{start: 1'b1, sub: 1'b0, a: now_reg,
                        b: TIME_W'(interval_reg)};
                    state_reg   <= ST_RST_W;
                end

                ST_RST_W: begin
                    if (alu_rsp.done) begin
                        next_reg    <= alu_rsp.sum;
                        pos_reg     <= '0;
                        bar_reg     <= '0;
                        playing_reg <= !playing_reg;
                        state_reg   <= ST_EMIT;
                    end
                end

                // next += interval
                ST_STEP: begin
                    alu_req_reg <= '{start: 1'b1, sub: 1'b0, a: next_reg,
                        b: TIME_W'(interval_reg)};
                    state_reg   <= ST_STEP_W;
                end

                ST_STEP_W: begin
                    if (alu_rsp.done) begin
                        next_reg    <= alu_rsp.sum;
                        alu_req_reg <= '{start: 1'b1, sub: 1'b1, a: alu_rsp.sum,
                            b: now_reg};
                        state_reg   <= ST_LATE_W;
                    end
                end

                // Late beat: next = now + interval
                ST_LATE_W: begin
                    if (alu_rsp.done) begin
                        if (alu_rsp.sum[TIME_W-1]) begin
                            alu_req_reg <= '{start: 1'b1, sub: 1'b0, a: now_reg,
                                b: TIME_W'(interval_reg)};
                            state_reg   <= ST_FIX_W;
                        end else begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end

                ST_FIX_W: begin
                    if (alu_rsp.done) begin
                        next_reg  <= alu_rsp.sum;
                        state_reg <= ST_EMIT;
                    end
                end

                // Load the output register once it is free
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= fired_reg;
                        m_tdata_reg  <= {playing_reg, tempo_reg, bar_reg, idx_reg,
                                         lvl_reg, ms_reg, hz_reg, sil_reg, acc_reg};
                        state_reg    <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks
    `AMS_ASSERT_IMP(a_alu_start_free, alu_req_reg.start, !alu_rsp.busy)
    `AMS_ASSERT_IMP(a_div_start_free, div_req_reg.start, !div_rsp.busy)
    `AMS_ASSERT_IMP(a_mvalid_from_emit, $rose(m_tvalid_reg), $past(state_reg == ST_EMIT))
    `AMS_ASSERT_NXT(a_tempo_hold,
        state_reg != ST_ACC_W && !(cfg_write && cfg_index == CFG_START_BPM),
        $stable(tempo_reg))

endmodule
